/* hdl/ttec_pkg.sv */
// Package for the text terminal escape controller.
// Holds shared types, character codes and register reset values.
// No dependencies.
package ttec_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL,
    ST_MOD_COL,
    ST_MOD_ROW
  } ttec_state_t;

  // Escape progress codes
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_SEEN  = 2'd1,
    ESC_ARG1  = 2'd2,
    ESC_ARG2  = 2'd3
  } ttec_esc_t;

  // Result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_COLUMNS = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_LEFT    = 3'd2;
  localparam logic [2:0] REG_RIGHT   = 3'd3;
  localparam logic [2:0] REG_UP      = 3'd4;
  localparam logic [2:0] REG_DOWN    = 3'd5;
  localparam logic [2:0] REG_HOME    = 3'd6;
  localparam logic [2:0] REG_CLEAR   = 3'd7;

  // Register reset values
  localparam logic [7:0] RST_COLUMNS = 8'd64;
  localparam logic [7:0] RST_ROWS    = 8'd25;
  localparam logic [7:0] RST_LEFT    = 8'd8;
  localparam logic [7:0] RST_RIGHT   = 8'd24;
  localparam logic [7:0] RST_UP      = 8'd25;
  localparam logic [7:0] RST_DOWN    = 8'd26;
  localparam logic [7:0] RST_HOME    = 8'd12;
  localparam logic [7:0] RST_CLEAR   = 8'd31;

  // Fixed character codes
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_UP      = 8'h41;
  localparam logic [7:0] CH_DOWN    = 8'h42;
  localparam logic [7:0] CH_RIGHT   = 8'h43;
  localparam logic [7:0] CH_LEFT    = 8'h44;
  localparam logic [7:0] CH_POS     = 8'h59;
  localparam logic [7:0] CH_COLOR   = 8'h5A;
  localparam logic [7:0] ARG_OFFSET = 8'h20;
  localparam logic [7:0] TAB_STEP   = 8'd4;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] symbol;
    logic [3:0] fore;
    logic [3:0] back;
    logic       last;
  } ttec_res_t;

  // Queue status seen by the sequencer
  typedef struct packed {
    logic room2;
    logic empty;
  } ttec_qstat_t;

endpackage

/* hdl/ttec_mod.sv */
// Shared iterative remainder unit: one restoring subtract/compare step per cycle.
// Eight steps per operand; depends on ttec_pkg.
module ttec_mod
  import ttec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] remainder
);

  logic [7:0] rem_r, rem_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [7:0] div_r, div_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [8:0] trial;
  logic [8:0] diff;

  // One shift, compare and subtract step
  always_comb begin
    trial    = {rem_r, sh_r[7]};
    diff     = trial - {1'b0, div_r};
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      sh_nxt   = dividend;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[7:0] : trial[7:0];
      sh_nxt  = {sh_r[6:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* hdl/ttec_outq.sv */
// Result queue between the sequencer and the output channel.
// Four entries, one push and one pop per cycle; depends on ttec_pkg.
module ttec_outq
  import ttec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ttec_res_t   push_data,
  input  logic        pop,
  output ttec_res_t   head,
  output ttec_qstat_t stat
);

  ttec_res_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_pop;

  // Advance pointers and count
  always_comb begin
    do_pop     = pop && (count_r != '0);
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.room2 = (count_r <= (QAW+1)'(QDEPTH - 2));

endmodule

/* hdl/text_terminal_escape_controller_top.sv */
// Top level of the text terminal escape controller.
// Uses ttec_pkg, ttec_mod (remainder unit) and ttec_outq (result queue).
//
// Usage:
//   in_*   : one terminal byte per transfer in in_tdata[7:0].
//   out_*  : result items; out_tuser is the kind (0 write, 1 scroll),
//            out_tlast marks the final result caused by one byte.
//   cfg_*  : register writes, taken at any edge with cfg_we high; write only
//            while the block is idle.
// Timing: a byte is taken in the idle state and decoded in the next cycle,
// and the result of an ordinary byte enters the queue in the cycle after
// decode. A write that wraps off the bottom row then passes through the
// scroll state, which pushes the scroll result. The second argument of ESC Y
// runs the shared remainder unit twice (column, then row), 8 steps each.
// The rate is set by the single sequencer and that remainder unit.
// Results wait in a four-entry queue; a byte is taken only while two slots
// are free, so a stalled receiver eventually holds off the input side.
// Reset clears cursor, colors, escape progress, the queue and sets the
// registers to their defaults.
module text_terminal_escape_controller_top
  import ttec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // tdata: in_byte[7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // tdata: column[7:0], row[15:8], symbol[23:16], fore_color[27:24],
  //        back_color[31:28]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // tuser: out_kind[0]
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  ttec_state_t state_r, state_nxt;
  ttec_esc_t   phase_r, phase_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [3:0]  fg_r, fg_nxt;
  logic [3:0]  bg_r, bg_nxt;
  logic        is_color_r, is_color_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  byte_r;

  logic [7:0]  cols_r, rows_r, left_r, right_r, up_r, down_r, home_r, clear_r;

  logic [7:0]  eff_cols, eff_rows;
  logic [8:0]  col_inc, row_inc, tab_pos;
  logic        bottom;
  logic [7:0]  arg_a, arg_b;

  logic        mod_start, mod_done;
  logic [7:0]  mod_dividend, mod_divisor, mod_rem;

  logic        q_push;
  ttec_res_t   q_data, q_head;
  ttec_qstat_t q_stat;
  logic        in_xfer;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= RST_COLUMNS;
      rows_r  <= RST_ROWS;
      left_r  <= RST_LEFT;
      right_r <= RST_RIGHT;
      up_r    <= RST_UP;
      down_r  <= RST_DOWN;
      home_r  <= RST_HOME;
      clear_r <= RST_CLEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: cols_r  <= cfg_wdata;
        REG_ROWS:    rows_r  <= cfg_wdata;
        REG_LEFT:    left_r  <= cfg_wdata;
        REG_RIGHT:   right_r <= cfg_wdata;
        REG_UP:      up_r    <= cfg_wdata;
        REG_DOWN:    down_r  <= cfg_wdata;
        REG_HOME:    home_r  <= cfg_wdata;
        REG_CLEAR:   clear_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Screen size with zero treated as one, and cursor arithmetic
  always_comb begin
    eff_cols = (cols_r == '0) ? 8'd1 : cols_r;
    eff_rows = (rows_r == '0) ? 8'd1 : rows_r;
    col_inc  = {1'b0, col_r} + 9'd1;
    row_inc  = {1'b0, row_r} + 9'd1;
    tab_pos  = {1'b0, col_r & ~8'd3} + {1'b0, TAB_STEP};
    bottom   = (row_inc >= {1'b0, eff_rows});
    arg_a    = first_r - ARG_OFFSET;
    arg_b    = byte_r - ARG_OFFSET;
  end

  assign in_tready = (state_r == ST_IDLE) && q_stat.room2;
  assign in_xfer   = in_tvalid && in_tready;

  // Sequencer: next state, cursor updates and result pushes
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    fg_nxt       = fg_r;
    bg_nxt       = bg_r;
    is_color_nxt = is_color_r;
    first_nxt    = first_r;
    mod_start    = 1'b0;
    mod_dividend = arg_a;
    mod_divisor  = eff_cols;
    q_push       = 1'b0;
    q_data       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_nxt = ST_IDLE;
        if (phase_r == ESC_SEEN) begin
          phase_nxt = ESC_NONE;
          case (byte_r)
            CH_UP:    if (row_r != '0) row_nxt = row_r - 8'd1;
            CH_DOWN:  if (row_inc < {1'b0, eff_rows}) row_nxt = row_inc[7:0];
            CH_RIGHT: if (col_inc < {1'b0, eff_cols}) col_nxt = col_inc[7:0];
            CH_LEFT:  if (col_r != '0) col_nxt = col_r - 8'd1;
            CH_POS: begin
              phase_nxt    = ESC_ARG1;
              is_color_nxt = 1'b0;
            end
            CH_COLOR: begin
              phase_nxt    = ESC_ARG1;
              is_color_nxt = 1'b1;
            end
            default: ;
          endcase
        end else if (phase_r == ESC_ARG1) begin
          first_nxt = byte_r;
          phase_nxt = ESC_ARG2;
        end else if (phase_r == ESC_ARG2) begin
          phase_nxt    = ESC_NONE;
          is_color_nxt = 1'b0;
          if (is_color_r) begin
            bg_nxt = arg_a[3:0];
            fg_nxt = arg_b[3:0];
          end else begin
            // Column remainder first, row follows
            mod_start    = 1'b1;
            mod_dividend = arg_a;
            mod_divisor  = eff_cols;
            state_nxt    = ST_MOD_COL;
          end
        end else if (byte_r == left_r) begin
          if (col_r != '0) col_nxt = col_r - 8'd1;
        end else if (byte_r == CH_TAB) begin
          if (tab_pos >= {1'b0, eff_cols}) begin
            col_nxt = '0;
            if (bottom) state_nxt = ST_SCROLL;
            else        row_nxt   = row_inc[7:0];
          end else begin
            col_nxt = tab_pos[7:0];
          end
        end else if (byte_r == CH_LF) begin
          col_nxt = '0;
          if (bottom) state_nxt = ST_SCROLL;
          else        row_nxt   = row_inc[7:0];
        end else if (byte_r == home_r) begin
          col_nxt = '0;
          row_nxt = '0;
        end else if (byte_r == CH_CR) begin
          col_nxt = '0;
        end else if (byte_r == right_r) begin
          if (col_inc < {1'b0, eff_cols}) col_nxt = col_inc[7:0];
        end else if (byte_r == up_r) begin
          if (row_r != '0) row_nxt = row_r - 8'd1;
        end else if (byte_r == down_r) begin
          if (row_inc < {1'b0, eff_rows}) row_nxt = row_inc[7:0];
        end else if (byte_r == CH_ESC) begin
          phase_nxt = ESC_SEEN;
        end else if (byte_r == clear_r) begin
          // drop the byte
        end else begin
          // Write the symbol, then advance with wrap
          q_push        = 1'b1;
          q_data.kind   = KIND_WRITE;
          q_data.column = col_r;
          q_data.row    = row_r;
          q_data.symbol = byte_r;
          q_data.fore   = fg_r;
          q_data.back   = bg_r;
          q_data.last   = 1'b1;
          if (col_inc >= {1'b0, eff_cols}) begin
            col_nxt = '0;
            if (bottom) begin
              state_nxt   = ST_SCROLL;
              q_data.last = 1'b0;
            end else begin
              row_nxt = row_inc[7:0];
            end
          end else begin
            col_nxt = col_inc[7:0];
          end
        end
      end

      ST_SCROLL: begin
        q_push      = 1'b1;
        q_data.kind = KIND_SCROLL;
        q_data.last = 1'b1;
        state_nxt   = ST_IDLE;
      end

      ST_MOD_COL: begin
        if (mod_done) begin
          col_nxt      = mod_rem;
          mod_start    = 1'b1;
          mod_dividend = arg_b;
          mod_divisor  = eff_rows;
          state_nxt    = ST_MOD_ROW;
        end
      end

      ST_MOD_ROW: begin
        if (mod_done) begin
          row_nxt   = mod_rem;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= ESC_NONE;
      col_r      <= '0;
      row_r      <= '0;
      fg_r       <= '0;
      bg_r       <= '0;
      is_color_r <= 1'b0;
      first_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      fg_r       <= fg_nxt;
      bg_r       <= bg_nxt;
      is_color_r <= is_color_nxt;
      first_r    <= first_nxt;
    end
  end

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_tdata;
    end
  end

  ttec_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  ttec_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (out_tready),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Drive the result channel from the queue head
  assign out_tvalid = !q_stat.empty;
  assign out_tdata  = {q_head.back, q_head.fore, q_head.symbol, q_head.row, q_head.column};
  assign out_tuser  = q_head.kind;
  assign out_tlast  = q_head.last;

endmodule
